[rtl/xlsu_pkg.sv]
// Shared types and constants for the x86 logic and shift unit.
`default_nettype none

package xlsu_pkg;

  typedef enum logic [3:0] {
    OPC_AND  = 4'd0,
    OPC_OR   = 4'd1,
    OPC_XOR  = 4'd2,
    OPC_NOT  = 4'd3,
    OPC_SHL  = 4'd4,
    OPC_SHR  = 4'd5,
    OPC_SAR  = 4'd6,
    OPC_SHLD = 4'd7,
    OPC_SHRD = 4'd8
  } opcode_t;

  typedef enum logic [1:0] {
    SZ_8  = 2'd0,
    SZ_16 = 2'd1,
    SZ_32 = 2'd2,
    SZ_64 = 2'd3
  } size_t;

  typedef struct packed {
    logic cf;
    logic of;
    logic sf;
    logic zf;
    logic pf;
    logic af;
  } flags_t;

  localparam logic [5:0] CNT_MASK64 = 6'h3F;
  localparam logic [5:0] CNT_MASK32 = 6'h1F;
  localparam logic [7:0] BYTE_MASK  = 8'hFF;

endpackage

`default_nettype wire

[rtl/x86_logic_shift_unit_core.sv]
// Top level: x86 AND/OR/XOR/NOT, SHL/SHR/SAR and SHLD/SHRD unit with flag update.
`default_nettype none

// Two-stage registered unit. An accepted item is captured in an input
// register, evaluated in one pass of combinational logic (logic ops, a
// 64-bit barrel shifter for the simple shifts and a 128-bit funnel shifter
// for SHLD/SHRD, followed by the SF/ZF/PF reduction) and written to an
// output register, which drives out_valid. While out_ready keeps the output
// moving it takes one item every cycle, limited by the shifter plus flag logic
// that sits between the two registers. in_ready drops only when both stages
// hold an item and out_ready is low, so a stalled result does not block the
// next item from entering. Operand size 8/16/32/64 masks the operands and
// the result; simple shifts use the count masked to 5 bits (6 at 64-bit
// size), double shifts use the count modulo the width. A zero effective
// count, NOT, and undefined opcodes 9..15 pass the incoming flags through.
module x86_logic_shift_unit_core
  import xlsu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input item channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_opcode,
  input  wire logic [1:0]  in_size_code,
  input  wire logic [63:0] in_operand_a,
  input  wire logic [63:0] in_operand_b,
  input  wire logic [7:0]  in_shift_count,
  input  wire logic        in_cf_in,
  input  wire logic        in_of_in,
  input  wire logic        in_sf_in,
  input  wire logic        in_zf_in,
  input  wire logic        in_pf_in,
  input  wire logic        in_af_in,
  // result item channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_result,
  output logic             out_cf_out,
  output logic             out_of_out,
  output logic             out_sf_out,
  output logic             out_zf_out,
  output logic             out_pf_out,
  output logic             out_af_out
);

  // ---------------------------------------------------------------------
  // Handshake / stage control
  // ---------------------------------------------------------------------
  logic s1_v_r, s1_v_nxt;
  logic out_v_r, out_v_nxt;
  logic out_adv;   // output register can take a new item this cycle
  logic in_acc;

  assign out_adv  = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || out_adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_v_nxt  = in_acc ? 1'b1 : (out_adv ? 1'b0 : s1_v_r);
    out_v_nxt = out_adv ? s1_v_r : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Input register (payload, no reset)
  // ---------------------------------------------------------------------
  logic [3:0]  op_r;
  logic [1:0]  size_r;
  logic [63:0] a_raw_r;
  logic [63:0] b_raw_r;
  logic [7:0]  cnt_r;
  flags_t      fl_in_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_opcode;
      size_r  <= in_size_code;
      a_raw_r <= in_operand_a;
      b_raw_r <= in_operand_b;
      cnt_r   <= in_shift_count;
      fl_in_r <= '{cf: in_cf_in, of: in_of_in, sf: in_sf_in,
                   zf: in_zf_in, pf: in_pf_in, af: in_af_in};
    end
  end

  // ---------------------------------------------------------------------
  // Execute
  // ---------------------------------------------------------------------
  function automatic logic msb_sel(input logic [63:0] v, input logic [1:0] sz);
    logic m;
    unique case (size_t'(sz))
      SZ_8:    m = v[7];
      SZ_16:   m = v[15];
      SZ_32:   m = v[31];
      default: m = v[63];
    endcase
    return m;
  endfunction

  logic [6:0]   w;          // operand width in bits
  logic [5:0]   w_m1;       // width - 1, mask for the double-shift count
  logic [63:0]  mask;
  logic [63:0]  a, b, a_sx;
  logic         sign;
  logic [5:0]   c, dc;
  logic [127:0] shl_ext;
  logic [64:0]  shr_ext;
  logic [64:0]  sar_ext;
  logic [127:0] shld_cat;
  logic [128:0] shld_sh;
  logic [127:0] shld_top;
  logic [127:0] shrd_cat;
  logic [128:0] shrd_sh;
  logic [63:0]  r;
  flags_t       fl;
  logic         upd;
  logic [63:0]  res_nxt;
  flags_t       fl_nxt;

  always_comb begin
    unique case (size_t'(size_r))
      SZ_8: begin
        w = 7'd8;  w_m1 = 6'd7;  mask = 64'h0000_0000_0000_00FF;
      end
      SZ_16: begin
        w = 7'd16; w_m1 = 6'd15; mask = 64'h0000_0000_0000_FFFF;
      end
      SZ_32: begin
        w = 7'd32; w_m1 = 6'd31; mask = 64'h0000_0000_FFFF_FFFF;
      end
      default: begin
        w = 7'd64; w_m1 = 6'd63; mask = 64'hFFFF_FFFF_FFFF_FFFF;
      end
    endcase

    a    = a_raw_r & mask;
    b    = b_raw_r & mask;
    sign = msb_sel(a, size_r);

    unique case (size_t'(size_r))
      SZ_8:    a_sx = {{56{a[7]}},  a[7:0]};
      SZ_16:   a_sx = {{48{a[15]}}, a[15:0]};
      SZ_32:   a_sx = {{32{a[31]}}, a[31:0]};
      default: a_sx = a;
    endcase

    c  = cnt_r[5:0] & ((size_t'(size_r) == SZ_64) ? CNT_MASK64 : CNT_MASK32);
    dc = cnt_r[5:0] & w_m1;

    // Simple shifts: the extra bit catches the last bit shifted out.
    // Counts past the width fall out naturally since a is masked.
    shl_ext = {64'd0, a} << c;
    shr_ext = {a, 1'b0} >> c;
    sar_ext = 65'($signed({a_sx, 1'b0}) >>> c);

    // SHLD: a:b packed in the low 2*width bits, shift left, take the upper
    // width back down; the carry lands at bit 2*width.
    shld_cat = ({64'd0, a} << w) | {64'd0, b};
    shld_sh  = {1'b0, shld_cat} << dc;
    shld_top = shld_sh[127:0] >> w;
    // SHRD: b:a right-justified, shift right, bit 0 is the carry.
    shrd_cat = ({64'd0, b} << w) | {64'd0, a};
    shrd_sh  = {shrd_cat, 1'b0} >> dc;

    r   = a;
    fl  = fl_in_r;
    upd = 1'b0;

    unique case (opcode_t'(op_r))
      OPC_AND, OPC_OR, OPC_XOR: begin
        if (opcode_t'(op_r) == OPC_AND)     r = a & b;
        else if (opcode_t'(op_r) == OPC_OR) r = a | b;
        else                                r = a ^ b;
        fl.cf = 1'b0;
        fl.of = 1'b0;
        fl.af = 1'b0;
        upd   = 1'b1;
      end
      OPC_NOT: begin
        r = ~a & mask;
      end
      OPC_SHL: begin
        if (c != 6'd0) begin
          r     = shl_ext[63:0] & mask;
          fl.cf = shl_ext[w];
          fl.of = (c == 6'd1) ? (msb_sel(r, size_r) ^ shl_ext[w]) : 1'b0;
          fl.af = 1'b0;
          upd   = 1'b1;
        end
      end
      OPC_SHR: begin
        if (c != 6'd0) begin
          r     = shr_ext[64:1];
          fl.cf = shr_ext[0];
          fl.of = (c == 6'd1) ? sign : 1'b0;
          fl.af = 1'b0;
          upd   = 1'b1;
        end
      end
      OPC_SAR: begin
        if (c != 6'd0) begin
          r     = sar_ext[64:1] & mask;
          fl.cf = sar_ext[0];
          fl.of = 1'b0;
          fl.af = 1'b0;
          upd   = 1'b1;
        end
      end
      OPC_SHLD: begin
        if (dc != 6'd0) begin
          r     = shld_top[63:0] & mask;
          fl.cf = shld_sh[{w, 1'b0}];
          fl.of = (cnt_r == 8'd1) ? (sign ^ msb_sel(r, size_r)) : 1'b0;
          fl.af = 1'b0;
          upd   = 1'b1;
        end
      end
      OPC_SHRD: begin
        // AF passes through on SHRD
        if (dc != 6'd0) begin
          r     = shrd_sh[64:1] & mask;
          fl.cf = shrd_sh[0];
          fl.of = (cnt_r == 8'd1) ? (sign ^ msb_sel(r, size_r)) : 1'b0;
          upd   = 1'b1;
        end
      end
      default: begin
        // undefined opcodes: value and flags pass through
      end
    endcase

    if (upd) begin
      fl.sf = msb_sel(r, size_r);
      fl.zf = (r == 64'd0);
      fl.pf = ~^(r[7:0] & BYTE_MASK);
    end

    res_nxt = r & mask;
    fl_nxt  = fl;
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [63:0] res_r;
  flags_t      fl_out_r;

  always_ff @(posedge clk) begin
    if (s1_v_r && out_adv) begin
      res_r    <= res_nxt;
      fl_out_r <= fl_nxt;
    end
  end

  assign out_valid  = out_v_r;
  assign out_result = res_r;
  assign out_cf_out = fl_out_r.cf;
  assign out_of_out = fl_out_r.of;
  assign out_sf_out = fl_out_r.sf;
  assign out_zf_out = fl_out_r.zf;
  assign out_pf_out = fl_out_r.pf;
  assign out_af_out = fl_out_r.af;

endmodule

`default_nettype wire

[rtl/xlsu_checker.sv]
// Port-level checker for the logic and shift unit, bound to the top level.
`default_nettype none

module xlsu_checker
  import xlsu_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [3:0]  in_opcode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_result,
  input wire logic        out_cf_out,
  input wire logic        out_of_out,
  input wire logic        out_zf_out,
  input wire logic        out_af_out
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result changed while stalled");

  // input only backs up when the output is stalled
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // a fresh result comes from an item accepted into the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a matching item");

  // logic ops clear CF/OF/AF and set ZF from the result
  a_logic_flags: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && $past(in_opcode == OPC_AND || in_opcode == OPC_OR
                              || in_opcode == OPC_XOR, 2)
    |-> !out_cf_out && !out_of_out && !out_af_out
        && (out_zf_out == (out_result == 64'd0)))
    else $error("logic op flags wrong");

endmodule

bind x86_logic_shift_unit_core xlsu_checker u_xlsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_opcode  (in_opcode),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_result (out_result),
  .out_cf_out (out_cf_out),
  .out_of_out (out_of_out),
  .out_zf_out (out_zf_out),
  .out_af_out (out_af_out)
);

`default_nettype wire

[bench/tb_x86_logic_shift_unit_core.sv]
// Self-checking testbench for the x86 logic, shift and double-shift unit.
`timescale 1ns / 100ps

module tb_x86_logic_shift_unit_core;
  import xlsu_pkg::*;

  // opcodes past SHRD: the unit passes value and flags straight through
  localparam logic [3:0] OPC_UNDEF_LO = 4'd9;
  localparam logic [3:0] OPC_UNDEF_HI = 4'd15;

  localparam int RANDOM_OPS  = 750;
  localparam int DRAIN_WAIT  = 8;  // quiet stretch after the last result

  // one instruction as driven on the input ports
  typedef struct packed {
    logic [3:0]  op;
    logic [1:0]  sz;
    logic [63:0] a;
    logic [63:0] b;
    logic [7:0]  cnt;
    flags_t      fl;
  } lsu_req_t;

  // value and flags that the unit hands back
  typedef struct packed {
    logic [63:0] value;
    flags_t      fl;
  } lsu_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_ready;
  lsu_req_t         cur_op = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [63:0]      out_result;
  logic             out_cf_out, out_of_out, out_sf_out;
  logic             out_zf_out, out_pf_out, out_af_out;

  lsu_req_t pending_ops[$];
  lsu_res_t predicted_results[$];

  logic     in_took = 1'b0;   // the item on the ports was taken at the last rising edge
  int       n_issued = 0;
  int       n_total = 0;
  int       mismatch_cnt = 0;
  int       idle_phase;
  int       send_idle_pct;
  int       recv_idle_pct;
  lsu_res_t want_res;
  lsu_res_t seen_res;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  x86_logic_shift_unit_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (cur_op.op),
    .in_size_code   (cur_op.sz),
    .in_operand_a   (cur_op.a),
    .in_operand_b   (cur_op.b),
    .in_shift_count (cur_op.cnt),
    .in_cf_in       (cur_op.fl.cf),
    .in_of_in       (cur_op.fl.of),
    .in_sf_in       (cur_op.fl.sf),
    .in_zf_in       (cur_op.fl.zf),
    .in_pf_in       (cur_op.fl.pf),
    .in_af_in       (cur_op.fl.af),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result     (out_result),
    .out_cf_out     (out_cf_out),
    .out_of_out     (out_of_out),
    .out_sf_out     (out_sf_out),
    .out_zf_out     (out_zf_out),
    .out_pf_out     (out_pf_out),
    .out_af_out     (out_af_out)
  );

  // Predicts value and flags of one instruction. Operands are cut to the
  // operand width first; simple shifts mask the count to 5 bits (6 at 64-bit
  // size), double shifts take it modulo the width.
  function automatic lsu_res_t shift_logic_eval(lsu_req_t rq);
    int unsigned w;
    int unsigned c;
    int unsigned dc;
    logic [63:0] mask;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    logic        sign;
    logic        upd;
    flags_t      f;
    lsu_res_t    res;
    w    = 8 << rq.sz;
    mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    a    = rq.a & mask;
    b    = rq.b & mask;
    c    = rq.cnt & ((w == 64) ? CNT_MASK64 : CNT_MASK32);
    dc   = rq.cnt % w;
    sign = a[w-1];
    f    = rq.fl;
    r    = a;
    upd  = 1'b0;
    case (rq.op)
      OPC_AND, OPC_OR, OPC_XOR: begin
        if (rq.op == OPC_AND)
          r = a & b;
        else if (rq.op == OPC_OR)
          r = a | b;
        else
          r = a ^ b;
        f.cf = 1'b0;
        f.of = 1'b0;
        f.af = 1'b0;
        upd  = 1'b1;
      end
      OPC_NOT: begin
        r = ~a & mask;  // flags untouched
      end
      OPC_SHL: begin
        if (c != 0) begin
          if (c < w) begin
            r    = (a << c) & mask;
            f.cf = a[w-c];
          end else begin
            r    = '0;
            f.cf = (c == w) ? a[0] : 1'b0;
          end
          f.of = (c == 1) ? (r[w-1] ^ f.cf) : 1'b0;
          f.af = 1'b0;
          upd  = 1'b1;
        end
      end
      OPC_SHR: begin
        if (c != 0) begin
          if (c < w) begin
            r    = a >> c;
            f.cf = a[c-1];
          end else begin
            r    = '0;
            f.cf = (c == w) ? sign : 1'b0;
          end
          f.of = (c == 1) ? sign : 1'b0;
          f.af = 1'b0;
          upd  = 1'b1;
        end
      end
      OPC_SAR: begin
        if (c != 0) begin
          if (c < w) begin
            r = a >> c;
            if (sign)
              r = r | (mask & ~(mask >> c));
            f.cf = a[c-1];
          end else begin
            r    = sign ? mask : '0;
            f.cf = sign;
          end
          f.of = 1'b0;
          f.af = 1'b0;
          upd  = 1'b1;
        end
      end
      OPC_SHLD: begin
        if (dc != 0) begin
          r    = ((a << dc) | (b >> (w - dc))) & mask;
          f.cf = a[w-dc];
          f.of = (rq.cnt == 8'd1) ? (sign ^ r[w-1]) : 1'b0;
          f.af = 1'b0;
          upd  = 1'b1;
        end
      end
      OPC_SHRD: begin
        if (dc != 0) begin
          r    = ((a >> dc) | (b << (w - dc))) & mask;
          f.cf = a[dc-1];
          f.of = (rq.cnt == 8'd1) ? (sign ^ r[w-1]) : 1'b0;
          upd  = 1'b1;  // AF passes through on SHRD
        end
      end
      default: begin
      end
    endcase
    if (upd) begin
      f.sf = r[w-1];
      f.zf = (r == '0);
      f.pf = ~^r[7:0];
    end
    res.value = r & mask;
    res.fl    = f;
    return res;
  endfunction

  task automatic queue_op(logic [3:0] op, logic [1:0] sz, logic [63:0] a, logic [63:0] b,
                          logic [7:0] cnt, logic [5:0] fl);
    lsu_req_t rq;
    rq.op  = op;
    rq.sz  = sz;
    rq.a   = a;
    rq.b   = b;
    rq.cnt = cnt;
    rq.fl  = fl;
    pending_ops.push_back(rq);
  endtask

  // operand mix: mostly random, with zero, all ones, one-hot and sign-heavy values
  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      3:       return {$urandom, $urandom} | (64'd1 << (8 << $urandom_range(0, 3)) - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Driver: a new item goes out at the falling edge once the previous one was
  // taken. The idle rate follows the three phases of the run: sender idle 29%
  // and receiver 52%, then swapped, then no idling at all.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      idle_phase    = (n_total == 0) ? 2 : (n_issued * 3) / n_total;
      send_idle_pct = (idle_phase == 0) ? 29 : (idle_phase == 1) ? 52 : 0;
      recv_idle_pct = (idle_phase == 0) ? 52 : (idle_phase == 1) ? 29 : 0;
      // a held item stays put, payload and all, until the unit takes it
      if (!in_valid || in_took) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_op   <= pending_ops.pop_front();
          in_valid <= 1'b1;
          n_issued <= n_issued + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on every accepted item, checks every accepted result
  // against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready)
        predicted_results.push_back(shift_logic_eval(cur_op));
      if (out_valid && out_ready) begin
        seen_res.value = out_result;
        seen_res.fl.cf = out_cf_out;
        seen_res.fl.of = out_of_out;
        seen_res.fl.sf = out_sf_out;
        seen_res.fl.zf = out_zf_out;
        seen_res.fl.pf = out_pf_out;
        seen_res.fl.af = out_af_out;
        if (predicted_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result %h with nothing outstanding", $realtime, out_result);
        end else begin
          want_res = predicted_results.pop_front();
          if (seen_res !== want_res) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"%0t: mismatch  expected %h cf%b of%b sf%b zf%b pf%b af%b",
                        "  got %h cf%b of%b sf%b zf%b pf%b af%b"}, $realtime,
                       want_res.value, want_res.fl.cf, want_res.fl.of, want_res.fl.sf,
                       want_res.fl.zf, want_res.fl.pf, want_res.fl.af,
                       seen_res.value, seen_res.fl.cf, seen_res.fl.of, seen_res.fl.sf,
                       seen_res.fl.zf, seen_res.fl.pf, seen_res.fl.af);
          end
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int          i;
    int          w;
    logic [3:0]  op;
    logic [1:0]  sz;
    logic [7:0]  cnt;
    logic [5:0]  fl;

    // logic ops: flag clearing, zero result, sign bit, NOT leaving flags alone
    queue_op(OPC_AND, SZ_64, '1, 64'hF0F0_F0F0_F0F0_F0F0, 8'd0, 6'b111111);
    queue_op(OPC_OR,  SZ_8,  '0, '0, 8'd3, 6'b000000);
    queue_op(OPC_XOR, SZ_16, 64'h1234_5678_9ABC_DEF0, 64'h1234_5678_9ABC_DEF0, 8'd0, 6'b110001);
    queue_op(OPC_XOR, SZ_32, 64'h0000_0000_8000_0000, 64'h1, 8'd0, 6'b101010);
    queue_op(OPC_NOT, SZ_8,  64'hFFFF_FFFF_FFFF_FF5A, '0, 8'd1, 6'b101010);
    // zero count passes everything through
    queue_op(OPC_SHL, SZ_32, 64'hDEAD_BEEF_CAFE_F00D, '0, 8'd0, 6'b110011);
    // SHL count 1 sets OF; count equal to and above the width
    queue_op(OPC_SHL, SZ_8,  64'h40, '0, 8'd1, 6'b000000);
    queue_op(OPC_SHL, SZ_8,  64'h81, '0, 8'd8, 6'b010101);
    queue_op(OPC_SHL, SZ_8,  64'hFF, '0, 8'd20, 6'b111111);
    // SHR count 1 gives OF from the old sign; count equal to width
    queue_op(OPC_SHR, SZ_16, 64'h8001, '0, 8'd1, 6'b000000);
    queue_op(OPC_SHR, SZ_16, 64'h8000, '0, 8'd16, 6'b000001);
    // SAR: sign fill, count above width, 64-bit count masking
    queue_op(OPC_SAR, SZ_32, 64'h8000_0000, '0, 8'd31, 6'b010000);
    queue_op(OPC_SAR, SZ_16, 64'h8000, '0, 8'd30, 6'b000000);
    queue_op(OPC_SAR, SZ_64, 64'h8000_0000_0000_0001, '0, 8'd63, 6'b000000);
    queue_op(OPC_SAR, SZ_64, 64'h7FFF_FFFF_FFFF_FFFF, '0, 8'd255, 6'b111111);
    queue_op(OPC_SAR, SZ_8,  64'h7F, '0, 8'd255, 6'b000000);
    // counts that mask down to zero
    queue_op(OPC_SHL, SZ_64, '1, '0, 8'h40, 6'b101101);
    queue_op(OPC_SHR, SZ_32, '1, '0, 8'h20, 6'b010010);
    // double shifts: count 1 OF, modulo-width counts, AF pass on SHRD
    queue_op(OPC_SHLD, SZ_32, 64'h4000_0001, 64'hFFFF_FFFF, 8'd1, 6'b000001);
    queue_op(OPC_SHLD, SZ_8,  64'hA5, 64'h3C, 8'd8, 6'b110110);
    queue_op(OPC_SHLD, SZ_8,  64'h40, 64'h80, 8'd9, 6'b000000);
    queue_op(OPC_SHRD, SZ_64, 64'h1, '1, 8'd1, 6'b000000);
    queue_op(OPC_SHRD, SZ_64, '1, '0, 8'd255, 6'b000001);
    queue_op(OPC_SHRD, SZ_16, 64'h8001, 64'h00FF, 8'd17, 6'b000001);
    // undefined opcodes
    queue_op(OPC_UNDEF_LO, SZ_16, '1, '1, 8'd255, 6'b100110);
    queue_op(OPC_UNDEF_HI, SZ_64, '1, '0, 8'd7, 6'b011001);

    // random part: mostly defined opcodes, counts biased toward the edges
    for (i = 0; i < RANDOM_OPS; i++) begin
      if ($urandom_range(0, 9) == 0)
        op = 4'($urandom_range(OPC_UNDEF_LO, OPC_UNDEF_HI));
      else
        op = 4'($urandom_range(OPC_AND, OPC_SHRD));
      sz = 2'($urandom_range(0, 3));
      w  = 8 << sz;
      case ($urandom_range(0, 3))
        0:       cnt = 8'($urandom_range(0, 255));
        1:       cnt = 8'($urandom_range(0, w + 1));
        2:       cnt = $urandom_range(0, 1) ? 8'd1 : 8'(w);
        default: cnt = 8'(w * $urandom_range(0, 3) + $urandom_range(0, 1));
      endcase
      fl = 6'($urandom);
      queue_op(op, sz, rand_operand(), rand_operand(), cnt, fl);
    end
    n_total = pending_ops.size();

    // reset held, then released away from the rising edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all items out, all results back, then a short quiet stretch
    while (pending_ops.size() != 0 || in_valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_cnt == 0)
      $display("x86_logic_shift_unit_core test passed");
    else
      $display("x86_logic_shift_unit_core test failed");
    $finish;
  end

  // watchdog, set far past the slowest legal run
  initial begin
    #4_000_000;
    $display("x86_logic_shift_unit_core test failed");
    $finish;
  end

endmodule

[sim.f]
rtl/xlsu_pkg.sv
rtl/x86_logic_shift_unit_core.sv
rtl/xlsu_checker.sv
bench/tb_x86_logic_shift_unit_core.sv
